// ----- hw/rtl/cc20_pkg.sv -----
package cc20_pkg;

    localparam int unsigned NumWords    = 16;
    localparam int unsigned DoubleRnds  = 10;
    localparam int unsigned QueueDepth  = 2;
    localparam int unsigned AddrW       = 6;

    localparam logic [31:0] Sigma0 = 32'h6170_7865;
    localparam logic [31:0] Sigma1 = 32'h3320_646e;
    localparam logic [31:0] Sigma2 = 32'h7962_2d32;
    localparam logic [31:0] Sigma3 = 32'h6b20_6574;

    typedef enum logic [2:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_NONCE0 = 3'd4,
        REG_NONCE1 = 3'd5,
        REG_CTR    = 3'd6
    } t_reg_idx;

    // classified beat handed from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic [5:0]  pos;
        logic        gen;
        logic [31:0] ctr;
    } t_cmd;

    typedef logic [31:0] t_words [NumWords];

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

endpackage

// ----- hw/rtl/chacha20_stream_xor.sv -----
// A byte at block position 0 waits while its block is generated: the load, 20 half-round steps
// of one shared quarter-round array, and the final add.
// Throughput: 1 byte/cycle for positions 1..63 while the receiver is not stalling the output.
// Reset (i_rst_n low, synchronous): registers, counter and position clear to 0;
// keystream is undefined until the first block is generated.
module chacha20_stream_xor #(
    parameter int unsigned QDepth = cc20_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [cc20_pkg::AddrW-1:0] paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import cc20_pkg::*;

    logic [63:0] r_key0, r_key1, r_key2, r_key3, r_nonce0;
    logic [31:0] r_nonce1, r_ictr;
    logic [2:0]  w_idx;
    t_cmd        w_fcmd, w_bcmd;
    logic        w_fval, w_frdy, w_bval, w_brdy;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0; r_key1 <= '0; r_key2 <= '0; r_key3 <= '0;
            r_nonce0 <= '0; r_nonce1 <= '0; r_ictr <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_KEY0:   r_key0   <= pwdata;
                REG_KEY1:   r_key1   <= pwdata;
                REG_KEY2:   r_key2   <= pwdata;
                REG_KEY3:   r_key3   <= pwdata;
                REG_NONCE0: r_nonce0 <= pwdata;
                REG_NONCE1: r_nonce1 <= pwdata[31:0];
                REG_CTR:    r_ictr   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_KEY0:   prdata = r_key0;
            REG_KEY1:   prdata = r_key1;
            REG_KEY2:   prdata = r_key2;
            REG_KEY3:   prdata = r_key3;
            REG_NONCE0: prdata = r_nonce0;
            REG_NONCE1: prdata = {32'd0, r_nonce1};
            REG_CTR:    prdata = {32'd0, r_ictr};
            default:    prdata = '0;
        endcase
    end

    cc20_front u_front (
        .i_clk, .i_rst_n,
        .i_valid, .o_ready,
        .i_data_byte, .i_restart,
        .i_init_ctr  (r_ictr),
        .o_cmd_valid (w_fval),
        .i_cmd_ready (w_frdy),
        .o_cmd       (w_fcmd)
    );

    cc20_queue #(.Depth(QDepth)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid (w_fval), .o_ready (w_frdy), .i_cmd (w_fcmd),
        .o_valid (w_bval), .i_ready (w_brdy), .o_cmd (w_bcmd)
    );

    cc20_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid (w_bval),
        .o_cmd_ready (w_brdy),
        .i_cmd       (w_bcmd),
        .i_key       ({r_key3, r_key2, r_key1, r_key0}),
        .i_nonce     ({r_nonce1, r_nonce0}),
        .o_valid, .i_ready, .o_out_byte
    );

endmodule

// ----- hw/rtl/cc20_front.sv -----
module cc20_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_restart,
    input  logic [31:0]     i_init_ctr,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output cc20_pkg::t_cmd  o_cmd
);
    import cc20_pkg::*;

    logic [31:0] r_ctr, n_ctr;
    logic [5:0]  r_pos;
    logic [31:0] w_ctr;
    logic [5:0]  w_pos;

    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign w_ctr       = i_restart ? i_init_ctr : r_ctr;
    assign w_pos       = i_restart ? 6'd0 : r_pos;
    assign n_ctr       = (w_pos == 6'd0) ? w_ctr + 32'd1 : w_ctr;

    always_comb begin
        o_cmd.data = i_data_byte;
        o_cmd.pos  = w_pos;
        o_cmd.gen  = (w_pos == 6'd0);
        o_cmd.ctr  = w_ctr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
            r_pos <= '0;
        end else if (i_valid && i_cmd_ready) begin
            r_ctr <= n_ctr;
            r_pos <= w_pos + 6'd1;
        end
    end

endmodule

// ----- hw/rtl/cc20_queue.sv -----
module cc20_queue #(
    parameter int unsigned Depth = cc20_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cc20_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output cc20_pkg::t_cmd  o_cmd
);
    import cc20_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

    t_cmd              r_mem [Depth];
    logic [PtrW-1:0]   r_wp, r_rp;
    logic [PtrW:0]     r_cnt;
    logic              w_push, w_pop;

    assign o_ready = (r_cnt != (PtrW+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PtrW'(Depth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PtrW'(Depth - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PtrW+1)'(w_push) - (PtrW+1)'(w_pop);
        end
    end

endmodule

// ----- hw/rtl/cc20_back.sv -----
module cc20_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  cc20_pkg::t_cmd  i_cmd,
    input  logic [255:0]    i_key,
    input  logic [95:0]     i_nonce,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte
);
    import cc20_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL
    } t_state;

    t_state      r_state;
    logic [31:0] r_init [NumWords];
    logic [31:0] r_work [NumWords];
    logic [31:0] r_ks   [NumWords];
    logic [31:0] n_work [NumWords];
    logic [4:0]  r_half;
    logic [7:0]  r_data;
    logic        r_oval;
    logic [7:0]  r_obyte;
    logic        w_out_free;
    logic [31:0] w_word;
    logic [7:0]  w_ks;

    // one quarter round
    function automatic logic [127:0] qr(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
        logic [31:0] ta, tb, tc, td;
        ta = a + b; td = rotl(d ^ ta, 16);
        tc = c + td; tb = rotl(b ^ tc, 12);
        ta = ta + tb; td = rotl(td ^ ta, 8);
        tc = tc + td; tb = rotl(tb ^ tc, 7);
        qr = {ta, tb, tc, td};
    endfunction

    // one half of a double round per cycle: column pass on even steps, diagonal on odd
    always_comb begin
        n_work = r_work;
        for (int q = 0; q < 4; q++) begin
            logic [1:0] ib, ic, id;
            ib = r_half[0] ? 2'(q + 1) : 2'(q);
            ic = r_half[0] ? 2'(q + 2) : 2'(q);
            id = r_half[0] ? 2'(q + 3) : 2'(q);
            {n_work[q], n_work[4 + ib], n_work[8 + ic], n_work[12 + id]} =
                qr(r_work[q], r_work[4 + ib], r_work[8 + ic], r_work[12 + id]);
        end
    end

    assign w_out_free  = !r_oval || i_ready;
    assign o_cmd_ready = (r_state == ST_IDLE) && w_out_free;
    assign o_valid     = r_oval;
    assign o_out_byte  = r_obyte;
    assign w_word      = r_ks[i_cmd.pos[5:2]];
    assign w_ks        = w_word[8*i_cmd.pos[1:0] +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_oval  <= 1'b0;
            r_half  <= '0;
        end else begin
            if (r_oval && i_ready) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid && w_out_free) begin
                        r_data <= i_cmd.data;
                        if (i_cmd.gen) begin
                            r_init[0] <= Sigma0; r_work[0] <= Sigma0;
                            r_init[1] <= Sigma1; r_work[1] <= Sigma1;
                            r_init[2] <= Sigma2; r_work[2] <= Sigma2;
                            r_init[3] <= Sigma3; r_work[3] <= Sigma3;
                            for (int k = 0; k < 8; k++) begin
                                r_init[4 + k] <= i_key[32*k +: 32];
                                r_work[4 + k] <= i_key[32*k +: 32];
                            end
                            r_init[12] <= i_cmd.ctr; r_work[12] <= i_cmd.ctr;
                            for (int k = 0; k < 3; k++) begin
                                r_init[13 + k] <= i_nonce[32*k +: 32];
                                r_work[13 + k] <= i_nonce[32*k +: 32];
                            end
                            r_half  <= '0;
                            r_state <= ST_ROUND;
                        end else begin
                            r_oval  <= 1'b1;
                            r_obyte <= i_cmd.data ^ w_ks;
                        end
                    end
                end
                ST_ROUND: begin
                    r_work <= n_work;
                    r_half <= r_half + 5'd1;
                    if (r_half == 5'(2 * DoubleRnds - 1)) begin
                        r_state <= ST_FINAL;
                    end
                end
                ST_FINAL: begin
                    for (int k = 0; k < NumWords; k++) begin
                        r_ks[k] <= r_work[k] + r_init[k];
                    end
                    r_state <= ST_IDLE;
                    // first byte of a block; output is free since input was taken when free
                    r_oval  <= 1'b1;
                    r_obyte <= r_data ^ 8'(r_work[0] + r_init[0]);
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- verif/chacha20_stream_xor_test.sv -----
module chacha20_stream_xor_test;
    import cc20_pkg::*;

    // Keystream predictor and the queue of bytes still owed by the block.
    class stream_scoreboard;
        bit [63:0] regs [7];
        bit [31:0] blk_ctr;
        bit [5:0]  pos;
        bit [31:0] ks_words [16];
        bit [7:0]  pending_bytes [$];
        int        mismatches;

        function void set_reg(t_reg_idx idx, bit [63:0] v);
            regs[idx] = v;
        endfunction

        function bit [31:0] rol(bit [31:0] v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function void qround(ref bit [31:0] w [16], input int a, int b, int c, int d);
            w[a] += w[b]; w[d] = rol(w[d] ^ w[a], 16);
            w[c] += w[d]; w[b] = rol(w[b] ^ w[c], 12);
            w[a] += w[b]; w[d] = rol(w[d] ^ w[a], 8);
            w[c] += w[d]; w[b] = rol(w[b] ^ w[c], 7);
        endfunction

        function void make_keystream();
            bit [31:0] st [16];
            bit [31:0] x [16];
            st[0]  = Sigma0;
            st[1]  = Sigma1;
            st[2]  = Sigma2;
            st[3]  = Sigma3;
            st[4]  = regs[REG_KEY0][31:0];
            st[5]  = regs[REG_KEY0][63:32];
            st[6]  = regs[REG_KEY1][31:0];
            st[7]  = regs[REG_KEY1][63:32];
            st[8]  = regs[REG_KEY2][31:0];
            st[9]  = regs[REG_KEY2][63:32];
            st[10] = regs[REG_KEY3][31:0];
            st[11] = regs[REG_KEY3][63:32];
            st[12] = blk_ctr;
            st[13] = regs[REG_NONCE0][31:0];
            st[14] = regs[REG_NONCE0][63:32];
            st[15] = regs[REG_NONCE1][31:0];
            x = st;
            for (int r = 0; r < 10; r++) begin
                qround(x, 0, 4, 8, 12);
                qround(x, 1, 5, 9, 13);
                qround(x, 2, 6, 10, 14);
                qround(x, 3, 7, 11, 15);
                qround(x, 0, 5, 10, 15);
                qround(x, 1, 6, 11, 12);
                qround(x, 2, 7, 8, 13);
                qround(x, 3, 4, 9, 14);
            end
            for (int i = 0; i < 16; i++) ks_words[i] = x[i] + st[i];
        endfunction

        function void note_input(bit [7:0] d, bit rs);
            bit [31:0] w;
            if (rs) begin
                blk_ctr = regs[REG_CTR][31:0];
                pos = 0;
            end
            if (pos == 0) begin
                make_keystream();
                blk_ctr++;
            end
            w = ks_words[pos[5:2]] >> (pos[1:0] * 8);
            pending_bytes.push_back(d ^ w[7:0]);
            pos++;
        endfunction

        function void check_out(bit [7:0] act);
            bit [7:0] exp_b;
            if (pending_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected out byte %02h", act);
                return;
            end
            exp_b = pending_bytes.pop_front();
            if (act !== exp_b) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("out byte mismatch: expected %02h got %02h", exp_b, act);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 0;
    logic        i_restart = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [7:0]  o_out_byte;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [AddrW-1:0] paddr = 0;
    logic [63:0] pwdata = 0;
    logic [63:0] prdata;
    logic        pready;

    stream_scoreboard sb = new();
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;
    int idle_cycles = 0;

    chacha20_stream_xor i_dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_input(i_data_byte, i_restart);
            if (o_valid && i_ready) sb.check_out(o_out_byte);
        end
    end

    // receiver: alternating stretches of always-ready, light and heavy stalling
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(5, 60);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: begin
                i_ready <= 1'b1;
            end
            1: begin
                i_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_ready <= ($urandom_range(0, 4) == 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 5000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // leaves psel high; the caller closes the transfer after the last write
    task automatic write_reg(t_reg_idx idx, logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'(8 * int'(idx));
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_reg(idx, v);
    endtask

    task automatic load_config(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                               logic [63:0] k3, logic [63:0] n0, logic [31:0] n1,
                               logic [31:0] ctr);
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_NONCE0, n0);
        write_reg(REG_NONCE1, {32'h0, n1});
        write_reg(REG_CTR, {32'h0, ctr});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_byte(logic [7:0] d, logic rs);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
        end
        i_valid     <= 1'b1;
        i_data_byte <= d;
        i_restart   <= rs;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        burst_left--;
    endtask

    // block may still be generating after the last byte; wait out its latency
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic send_random(int n, int restart_pct);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < restart_pct);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no restart after reset: stream starts at counter 0 with all-zero key
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        drain();

        // all-ones key/nonce, counter at its top so the next block wraps
        load_config('1, '1, '1, '1, '1, '1, 32'hFFFF_FFFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h3C, 1'b1);
        send_byte(8'hC3, 1'b1);
        for (int i = 0; i < 12; i++) send_byte(i[7:0], 1'b0);
        drain();

        // key change mid-block: current block keeps the old key
        load_config('0, '0, '0, '0, '0, '0, 32'h0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h01, 1'b1);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            load_config(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom,
                        (ph == 1) ? 32'hFFFF_FFFE : $urandom);
            send_random(100, (ph == 4) ? 20 : 3);
            drain();
        end

        if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
